FILE: sv/tbpr_pkg.sv
package tbpr_pkg;

    // Store geometry.
    localparam int MAP_BYTES    = 1024;
    localparam int TILE_COUNT   = 256;
    localparam int GFX_BYTES    = 4096;
    localparam int COLOUR_DEPTH = 32;
    localparam int LOOKUP_DEPTH = 256;

    localparam int MAP_AW    = $clog2(MAP_BYTES);
    localparam int TILE_W    = $clog2(TILE_COUNT);
    localparam int GFX_AW    = $clog2(GFX_BYTES);
    localparam int COLOUR_AW = $clog2(COLOUR_DEPTH);
    localparam int LOOKUP_AW = $clog2(LOOKUP_DEPTH);

    // Request codes carried on the func field.
    localparam logic [2:0] FN_WR_TILE   = 3'd0;
    localparam logic [2:0] FN_WR_ATTR   = 3'd1;
    localparam logic [2:0] FN_WR_GFX    = 3'd2;
    localparam logic [2:0] FN_WR_COLOUR = 3'd3;
    localparam logic [2:0] FN_WR_LOOKUP = 3'd4;
    localparam logic [2:0] FN_RENDER    = 3'd5;

    // Palette number that marks the transparent pen.
    localparam logic [4:0] TRANSPARENT_PAL = 5'h1f;

    // Colour weights of the resistor network.
    localparam logic [7:0] WEIGHT_LO  = 8'h21;
    localparam logic [7:0] WEIGHT_MID = 8'h47;
    localparam logic [7:0] WEIGHT_HI  = 8'h97;

    // Row offset and column rotation of the cell mapping.
    localparam logic [5:0] ROW_OFFSET = 6'd2;
    localparam logic [5:0] COL_OFFSET = 6'd2;

    // Maps a screen cell to an index of the tile RAMs, using the wrapped
    // rule for the side column pairs.
    function automatic logic [MAP_AW-1:0] map_index(input logic [8:0] x, input logic [7:0] y);
        logic [5:0]        col;
        logic [5:0]        row;
        logic [MAP_AW-1:0] idx;
        col = x[8:3] - COL_OFFSET;
        row = {1'b0, y[7:3]} + ROW_OFFSET;
        if (col[5]) begin
            idx = {col[4:0], 5'b0} + {{(MAP_AW-6){1'b0}}, row};
        end else begin
            idx = {row[4:0], 5'b0} + {{(MAP_AW-6){1'b0}}, col};
        end
        return idx;
    endfunction

    // Weighted sum of three colour bits, taken modulo 256.
    function automatic logic [7:0] weigh3(input logic lo, input logic mid, input logic hi);
        return (lo ? WEIGHT_LO : 8'h00) + (mid ? WEIGHT_MID : 8'h00)
             + (hi ? WEIGHT_HI : 8'h00);
    endfunction

endpackage

FILE: sv/tilemap_background_pixel_renderer.sv
// Channel  | Ports                                           | Direction
// ---------+-------------------------------------------------+----------
// request  | s_valid s_ready s_func s_addr s_wdata           | in
//          | s_pixel_x s_pixel_y                             |
// result   | m_valid m_ready m_red m_green m_blue            | out
//          | m_transparent                                   |
//
// One request enters per clock while the result side does not stall; a render
// request passes the four store stages and the output register behind the
// input register before its pixel appears.
// The rate is set by the single read port of each store.
// Reset (aresetn low at a clock edge) empties every stage; store contents
// are kept and are undefined until written.
// A stall on the result side freezes all stages behind the output register;
// the input register may still take a request while it is empty.
module tilemap_background_pixel_renderer
    import tbpr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [11:0] s_addr,
    input  logic [7:0]  s_wdata,
    input  logic [8:0]  s_pixel_x,
    input  logic [7:0]  s_pixel_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic        m_transparent
);

    // The five stores. Each is written by a write request at the very stage
    // where render requests read it, so that requests keep their order of
    // effect without any forwarding.
    logic [7:0] tile_code_ram [MAP_BYTES];
    logic [7:0] tile_attr_ram [MAP_BYTES];
    logic [7:0] gfx_rom       [GFX_BYTES];
    logic [7:0] colour_prom   [COLOUR_DEPTH];
    logic [3:0] lookup_prom   [LOOKUP_DEPTH];

    // Stage 0: the input register.
    logic        v0_reg;
    logic [2:0]  func0_reg;
    logic [11:0] addr0_reg;
    logic [7:0]  wdata0_reg;
    logic [8:0]  x0_reg;
    logic [7:0]  y0_reg;

    // Stage 1: tile code and attribute have been read.
    logic              v1_reg;
    logic [2:0]        func1_reg;
    logic [11:0]       addr1_reg;
    logic [7:0]        wdata1_reg;
    logic [2:0]        px1_reg;
    logic [2:0]        py1_reg;
    logic [TILE_W-1:0] code1_reg;
    logic [7:0]        attr1_reg;

    // Stage 2: the graphics byte has been read.
    logic        v2_reg;
    logic [2:0]  func2_reg;
    logic [11:0] addr2_reg;
    logic [7:0]  wdata2_reg;
    logic [1:0]  px2_reg;
    logic [4:0]  pal2_reg;
    logic [7:0]  gfx2_reg;

    // Stage 3: the colour index has been looked up.
    logic        v3_reg;
    logic [2:0]  func3_reg;
    logic [11:0] addr3_reg;
    logic [7:0]  wdata3_reg;
    logic        transp3_reg;
    logic [3:0]  cidx3_reg;

    // Stage 4: the colour byte has been read.
    logic        v4_reg;
    logic [2:0]  func4_reg;
    logic        transp4_reg;
    logic [7:0]  colour4_reg;

    // Output register.
    logic        m_valid_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;
    logic        transp_reg;

    logic                 advance;
    logic [MAP_AW-1:0]    map_idx_next;
    logic [GFX_AW-1:0]    gfx_addr_next;
    logic [1:0]           shift_next;
    logic [1:0]           pen_next;
    logic [LOOKUP_AW-1:0] lookup_addr_next;
    logic                 render4;

    // All stages move together whenever the output register is free or
    // being emptied in this cycle.
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !v0_reg || advance;

    assign map_idx_next = map_index(x0_reg, y0_reg);

    // For the left half of a tile row the second eight bytes hold the
    // pixels; within each byte the bit position is three minus the low two
    // bits of the column, with the second plane four bits higher.
    assign gfx_addr_next    = {code1_reg, ~px1_reg[2], py1_reg};
    assign shift_next       = ~px2_reg;
    assign pen_next         = {gfx2_reg[{1'b1, shift_next}], gfx2_reg[{1'b0, shift_next}]};
    assign lookup_addr_next = {1'b0, pal2_reg, pen_next};
    assign render4          = v4_reg && (func4_reg == FN_RENDER);

    // Valid bits of the pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                v0_reg <= s_valid;
            end
            if (advance) begin
                v1_reg      <= v0_reg;
                v2_reg      <= v1_reg;
                v3_reg      <= v2_reg;
                v4_reg      <= v3_reg;
                m_valid_reg <= render4;
            end
        end
    end

    // Payload of the pipeline.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            func0_reg  <= s_func;
            addr0_reg  <= s_addr;
            wdata0_reg <= s_wdata;
            x0_reg     <= s_pixel_x;
            y0_reg     <= s_pixel_y;
        end
        if (advance) begin
            func1_reg   <= func0_reg;
            addr1_reg   <= addr0_reg;
            wdata1_reg  <= wdata0_reg;
            px1_reg     <= x0_reg[2:0];
            py1_reg     <= y0_reg[2:0];

            func2_reg   <= func1_reg;
            addr2_reg   <= addr1_reg;
            wdata2_reg  <= wdata1_reg;
            px2_reg     <= px1_reg[1:0];
            pal2_reg    <= attr1_reg[4:0];

            func3_reg   <= func2_reg;
            addr3_reg   <= addr2_reg;
            wdata3_reg  <= wdata2_reg;
            transp3_reg <= (pal2_reg == TRANSPARENT_PAL);

            func4_reg   <= func3_reg;
            transp4_reg <= transp3_reg;

            // Blue has no low bit, so it takes only the middle and high
            // weights.
            red_reg     <= weigh3(colour4_reg[0], colour4_reg[1], colour4_reg[2]);
            green_reg   <= weigh3(colour4_reg[3], colour4_reg[4], colour4_reg[5]);
            blue_reg    <= weigh3(1'b0, colour4_reg[6], colour4_reg[7]);
            transp_reg  <= transp4_reg;
        end
    end

    // Tile code RAM, read and written between stage 0 and stage 1.
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (v0_reg && func0_reg == FN_WR_TILE) begin
                tile_code_ram[addr0_reg[MAP_AW-1:0]] <= wdata0_reg;
            end
            code1_reg <= tile_code_ram[map_idx_next][TILE_W-1:0];
        end
    end

    // Tile attribute RAM, at the same stage as the code RAM.
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (v0_reg && func0_reg == FN_WR_ATTR) begin
                tile_attr_ram[addr0_reg[MAP_AW-1:0]] <= wdata0_reg;
            end
            attr1_reg <= tile_attr_ram[map_idx_next];
        end
    end

    // Graphics ROM, between stage 1 and stage 2.
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (v1_reg && func1_reg == FN_WR_GFX) begin
                gfx_rom[addr1_reg[GFX_AW-1:0]] <= wdata1_reg;
            end
            gfx2_reg <= gfx_rom[gfx_addr_next];
        end
    end

    // Palette lookup PROM, between stage 2 and stage 3. Only the low four
    // bits of a written byte are kept.
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (v2_reg && func2_reg == FN_WR_LOOKUP) begin
                lookup_prom[addr2_reg[LOOKUP_AW-1:0]] <= wdata2_reg[3:0];
            end
            cidx3_reg <= lookup_prom[lookup_addr_next];
        end
    end

    // Colour PROM, between stage 3 and stage 4.
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (v3_reg && func3_reg == FN_WR_COLOUR) begin
                colour_prom[addr3_reg[COLOUR_AW-1:0]] <= wdata3_reg;
            end
            colour4_reg <= colour_prom[{{(COLOUR_AW-4){1'b0}}, cidx3_reg}];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_red         = red_reg;
    assign m_green       = green_reg;
    assign m_blue        = blue_reg;
    assign m_transparent = transp_reg;

endmodule

FILE: bench/tb_tilemap_background_pixel_renderer.sv
`timescale 1ns / 1ps

module tb_tilemap_background_pixel_renderer;
    import tbpr_pkg::*;

    // The two func codes that the block does not use. Requests carrying them
    // are swallowed without a pixel.
    localparam logic [2:0] FN_SPARE_LO = 3'd6;
    localparam logic [2:0] FN_SPARE_HI = 3'd7;

    localparam int RANDOM_REQUESTS = 1750;
    localparam int STALL_CYCLES    = 400;
    localparam int STALL_AFTER     = 40;
    localparam int DRAIN_CYCLES    = 24;
    localparam longint WATCHDOG_NS = 20_000_000;

    typedef struct packed {
        logic [2:0]  func;
        logic [11:0] addr;
        logic [7:0]  wdata;
        logic [8:0]  x;
        logic [7:0]  y;
    } bg_request_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       transparent;
    } rgb_pixel_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [2:0]  s_func        = '0;
    logic [11:0] s_addr        = '0;
    logic [7:0]  s_wdata       = '0;
    logic [8:0]  s_pixel_x     = '0;
    logic [7:0]  s_pixel_y     = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [7:0]  m_red;
    logic [7:0]  m_green;
    logic [7:0]  m_blue;
    logic        m_transparent;

    tilemap_background_pixel_renderer u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_addr        (s_addr),
        .s_wdata       (s_wdata),
        .s_pixel_x     (s_pixel_x),
        .s_pixel_y     (s_pixel_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_transparent (m_transparent)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shadow copy of the five stores, updated in request order as each
    // request is accepted, and the queue of pixels still owed by the block.
    // ------------------------------------------------------------------
    logic [7:0] code_mem   [MAP_BYTES];
    logic [7:0] attr_mem   [MAP_BYTES];
    logic [7:0] gfx_mem    [GFX_BYTES];
    logic [7:0] colour_mem [COLOUR_DEPTH];
    logic [3:0] lookup_mem [LOOKUP_DEPTH];

    rgb_pixel_t  pixel_q[$];
    bg_request_t req_q[$];

    int n_items     = 0;
    int n_real      = 0;
    int n_accepted  = 0;
    int pixels_seen = 0;
    int errors      = 0;

    // Map index of the 8x8 cell holding a pixel. The two column pairs at
    // either side of the screen land in the wrapped part of the map, where
    // rows and columns trade places. Off-screen pixels simply wrap round.
    function automatic logic [MAP_AW-1:0] cell_of(input logic [8:0] x, input logic [7:0] y);
        int col;
        int row;
        int idx;
        col = (int'(x[8:3]) + 64 - int'(COL_OFFSET)) % 64;
        row = int'(y[7:3]) + int'(ROW_OFFSET);
        if (col >= 32) begin
            idx = row + (col - 32) * 32;
        end else begin
            idx = col + row * 32;
        end
        return MAP_AW'(idx % MAP_BYTES);
    endfunction

    // Graphics byte that carries a pixel of a tile: the left half of the
    // tile sits in the upper eight bytes of its sixteen.
    function automatic logic [GFX_AW-1:0] gfx_addr_of(input logic [7:0] code,
                                                      input logic [8:0] x,
                                                      input logic [7:0] y);
        int base;
        base = int'(code) * 16 + int'(y[2:0]);
        if (x[2:0] < 3'd4) begin
            base = base + 8;
        end
        return GFX_AW'(base % GFX_BYTES);
    endfunction

    function automatic logic [7:0] intensity(input logic lo, input logic mid, input logic hi);
        int sum;
        sum = 0;
        if (lo)  sum = sum + int'(WEIGHT_LO);
        if (mid) sum = sum + int'(WEIGHT_MID);
        if (hi)  sum = sum + int'(WEIGHT_HI);
        return 8'(sum);
    endfunction

    // Applies one accepted request to the shadow stores; a render request
    // also works out the pixel that must come back for it.
    task automatic predict_request(input bg_request_t r);
        logic [MAP_AW-1:0] cell_idx;
        logic [4:0]        pal;
        logic [7:0]        gbyte;
        logic [1:0]        shift;
        logic [1:0]        pen;
        logic [3:0]        cidx;
        logic [7:0]        c;
        rgb_pixel_t        p;
        case (r.func)
            FN_WR_TILE:   code_mem[r.addr[MAP_AW-1:0]]      = r.wdata;
            FN_WR_ATTR:   attr_mem[r.addr[MAP_AW-1:0]]      = r.wdata;
            FN_WR_GFX:    gfx_mem[r.addr[GFX_AW-1:0]]       = r.wdata;
            FN_WR_COLOUR: colour_mem[r.addr[COLOUR_AW-1:0]] = r.wdata;
            FN_WR_LOOKUP: lookup_mem[r.addr[LOOKUP_AW-1:0]] = r.wdata[3:0];
            FN_RENDER: begin
                cell_idx = cell_of(r.x, r.y);
                pal      = attr_mem[cell_idx][4:0];
                gbyte    = gfx_mem[gfx_addr_of(code_mem[cell_idx], r.x, r.y)];
                // Both halves of the tile use the same bit order within
                // their nibble pair: plane 0 low, plane 1 high.
                shift = 2'd3 - r.x[1:0];
                pen   = {gbyte[shift + 4], gbyte[shift]};
                cidx  = lookup_mem[{1'b0, pal, pen}];
                c     = colour_mem[{1'b0, cidx}];
                p.red         = intensity(c[0], c[1], c[2]);
                p.green       = intensity(c[3], c[4], c[5]);
                p.blue        = intensity(1'b0, c[6], c[7]);
                p.transparent = (pal == TRANSPARENT_PAL);
                pixel_q.push_back(p);
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request planning. The block must never read a store entry that was
    // never written, so the planner keeps its own record of what has been
    // written (and the values it needs to follow the chain) and writes any
    // missing entry with random data before it asks for a pixel.
    // ------------------------------------------------------------------
    logic [7:0] plan_code   [MAP_BYTES];
    logic [7:0] plan_attr   [MAP_BYTES];
    logic [3:0] plan_lookup [LOOKUP_DEPTH];
    bit         tile_set    [MAP_BYTES];
    bit         attr_set    [MAP_BYTES];
    bit         gfx_set     [GFX_BYTES];
    bit         colour_set  [COLOUR_DEPTH];
    bit         lookup_set  [LOOKUP_DEPTH];

    task automatic schedule_request(input logic [2:0] func, input logic [11:0] addr,
                                    input logic [7:0] wdata, input logic [8:0] x,
                                    input logic [7:0] y);
        req_q.push_back('{func, addr, wdata, x, y});
        case (func)
            FN_WR_TILE: begin
                plan_code[addr[MAP_AW-1:0]] = wdata;
                tile_set[addr[MAP_AW-1:0]]  = 1'b1;
            end
            FN_WR_ATTR: begin
                plan_attr[addr[MAP_AW-1:0]] = wdata;
                attr_set[addr[MAP_AW-1:0]]  = 1'b1;
            end
            FN_WR_GFX:    gfx_set[addr[GFX_AW-1:0]] = 1'b1;
            FN_WR_COLOUR: colour_set[addr[COLOUR_AW-1:0]] = 1'b1;
            FN_WR_LOOKUP: begin
                plan_lookup[addr[LOOKUP_AW-1:0]] = wdata[3:0];
                lookup_set[addr[LOOKUP_AW-1:0]]  = 1'b1;
            end
            default: ;
        endcase
        if (func <= FN_RENDER) begin
            n_real++;
        end
    endtask

    // Writes with random upper address bits, which the block must drop.
    task automatic schedule_write(input logic [2:0] func, input int entry, input int depth);
        logic [11:0] addr;
        addr = 12'(($urandom & ~(depth - 1)) | entry);
        schedule_request(func, addr, 8'($urandom), 9'($urandom), 8'($urandom));
    endtask

    // Fills in whatever the pixel still lacks, then asks for it. All four
    // pens of the palette are prepared, as the planner does not track the
    // graphics data.
    task automatic schedule_pixel(input logic [8:0] x, input logic [7:0] y);
        logic [MAP_AW-1:0] cell_idx;
        logic [GFX_AW-1:0] gaddr;
        logic [4:0]        pal;
        logic [7:0]        la;
        cell_idx = cell_of(x, y);
        if (!tile_set[cell_idx]) schedule_write(FN_WR_TILE, int'(cell_idx), MAP_BYTES);
        if (!attr_set[cell_idx]) schedule_write(FN_WR_ATTR, int'(cell_idx), MAP_BYTES);
        gaddr = gfx_addr_of(plan_code[cell_idx], x, y);
        pal   = plan_attr[cell_idx][4:0];
        if (!gfx_set[gaddr]) schedule_write(FN_WR_GFX, int'(gaddr), GFX_BYTES);
        for (int pen = 0; pen < 4; pen++) begin
            la = {1'b0, pal, 2'(pen)};
            if (!lookup_set[la]) schedule_write(FN_WR_LOOKUP, int'(la), LOOKUP_DEPTH);
            if (!colour_set[{1'b0, plan_lookup[la]}]) begin
                schedule_write(FN_WR_COLOUR, int'(plan_lookup[la]), COLOUR_DEPTH);
            end
        end
        schedule_request(FN_RENDER, 12'($urandom), 8'($urandom), x, y);
    endtask

    // Idle lengths for both sides: mostly none or short, now and then long.
    // A calm spell gives long stretches with no idling at all.
    function automatic int idle_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Request side. The driver presents a new request at the falling edge
    // once the previous one has been taken; the tracker below notes each
    // acceptance at the rising edge and feeds it to the predictor.
    // ------------------------------------------------------------------
    logic        req_taken = 1'b0;
    int          send_gap  = 0;
    bit          send_calm = 1'b0;
    bg_request_t next_req;

    always @(posedge aclk) begin
        req_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            predict_request('{s_func, s_addr, s_wdata, s_pixel_x, s_pixel_y});
            n_accepted++;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !req_taken) begin
            // Still waiting for the block: hold the request as it is.
        end else if (send_gap > 0) begin
            s_valid  <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (req_q.size() > 0) begin
            next_req   = req_q.pop_front();
            s_valid   <= 1'b1;
            s_func    <= next_req.func;
            s_addr    <= next_req.addr;
            s_wdata   <= next_req.wdata;
            s_pixel_x <= next_req.x;
            s_pixel_y <= next_req.y;
            send_gap  <= idle_gap(send_calm);
            if ($urandom_range(0, 199) == 0) send_calm <= ~send_calm;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result side. Ready drops at random; once, after a few dozen pixels,
    // it stays low for a long spell while requests keep coming, so that the
    // pipeline fills and the block has to refuse requests.
    // ------------------------------------------------------------------
    int recv_gap   = 0;
    bit recv_calm  = 1'b0;
    int stall_left = 0;
    bit stall_done = 1'b0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!stall_done && pixels_seen >= STALL_AFTER) begin
            m_ready    <= 1'b0;
            stall_done <= 1'b1;
            stall_left <= STALL_CYCLES;
        end else if (recv_gap > 0) begin
            m_ready  <= 1'b0;
            recv_gap <= recv_gap - 1;
        end else begin
            m_ready  <= 1'b1;
            recv_gap <= idle_gap(recv_calm);
            if ($urandom_range(0, 199) == 0) recv_calm <= ~recv_calm;
        end
    end

    rgb_pixel_t want;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            pixels_seen++;
            if (pixel_q.size() == 0) begin
                $error("pixel with no render request waiting: rgb %h %h %h, transparent %b",
                       m_red, m_green, m_blue, m_transparent);
                errors++;
            end else begin
                want = pixel_q.pop_front();
                if (m_red !== want.red) begin
                    $error("red: expected %h, got %h", want.red, m_red);
                    errors++;
                end
                if (m_green !== want.green) begin
                    $error("green: expected %h, got %h", want.green, m_green);
                    errors++;
                end
                if (m_blue !== want.blue) begin
                    $error("blue: expected %h, got %h", want.blue, m_blue);
                    errors++;
                end
                if (m_transparent !== want.transparent) begin
                    $error("transparent: expected %b, got %b",
                           want.transparent, m_transparent);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        int r;
        int x0;
        int y0;
        int run;

        // Directed part. The first pixel reads the highest entry that a render
        // can reach in every store that it touches: the last map entry (reached
        // from an off-screen row in a wrapped column), the last graphics byte,
        // palette 31 with pen 3 and a colour byte with every bit set, so it is
        // transparent and at full intensity. The lookup write also carries a high
        // nibble that must be dropped, and the colour write an address beyond the
        // PROM that must wrap.
        schedule_request(FN_WR_TILE, 12'hfff, 8'hff, 9'h1ff, 8'hff);
        schedule_request(FN_WR_ATTR, 12'hfff, 8'hff, 9'h000, 8'h00);
        schedule_request(FN_WR_GFX, 12'hfff, 8'hff, 9'h1ff, 8'h00);
        schedule_request(FN_WR_LOOKUP, 12'h07f, 8'hff, 9'h000, 8'hff);
        schedule_request(FN_WR_COLOUR, 12'hfef, 8'hff, 9'h1ff, 8'hff);
        schedule_pixel(9'd8, 8'd239);
        // Bottom entries with zero data, and the top of the colour and
        // lookup address ranges, which renders never read back.
        schedule_request(FN_WR_COLOUR, 12'h000, 8'h00, 9'h000, 8'h00);
        schedule_request(FN_WR_LOOKUP, 12'h000, 8'h00, 9'h000, 8'h00);
        schedule_request(FN_WR_COLOUR, 12'hfff, 8'h5a, 9'h000, 8'h00);
        schedule_request(FN_WR_LOOKUP, 12'hfff, 8'hf0, 9'h000, 8'h00);
        // The unused codes must be ignored whatever the other fields hold.
        schedule_request(FN_SPARE_LO, 12'hfff, 8'hff, 9'h1ff, 8'hff);
        schedule_request(FN_SPARE_HI, 12'h000, 8'h00, 9'h000, 8'h00);
        // Screen corners (both in the wrapped side columns), the largest
        // off-screen pixel and one in the ordinary part of the map.
        schedule_pixel(9'd0, 8'd0);
        schedule_pixel(9'd287, 8'd223);
        schedule_pixel(9'h1ff, 8'hff);
        schedule_pixel(9'd100, 8'd37);

        // Random part. Most of it is short runs along a scan line, as the
        // video timing would ask for them; the rest is stray pixels anywhere, on
        // or off the screen, overwrites of any store and unused codes.
        while (n_real < RANDOM_REQUESTS) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                x0  = $urandom_range(0, 287);
                y0  = $urandom_range(0, 223);
                run = $urandom_range(1, 8);
                for (int k = 0; k < run; k++) begin
                    schedule_pixel(9'(x0 + k), 8'(y0));
                end
            end else if (r < 75) begin
                schedule_pixel(9'($urandom), 8'($urandom));
            end else if (r < 93) begin
                schedule_request(3'($urandom_range(FN_WR_TILE, FN_WR_LOOKUP)),
                                 12'($urandom), 8'($urandom), 9'($urandom), 8'($urandom));
            end else begin
                schedule_request($urandom_range(0, 1) ? FN_SPARE_HI : FN_SPARE_LO,
                                 12'($urandom), 8'($urandom), 9'($urandom), 8'($urandom));
            end
        end
        n_items = req_q.size();

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (n_accepted < n_items) @(posedge aclk);
        while (pixel_q.size() > 0) @(posedge aclk);
        // Let any stray pixel still in the pipeline show itself.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("tb_tilemap_background_pixel_renderer: done, clean");
        end else begin
            $display("tb_tilemap_background_pixel_renderer: done, errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, so only a hang ends here.
    initial begin
        #(WATCHDOG_NS);
        $display("tb_tilemap_background_pixel_renderer: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
sv/tbpr_pkg.sv
sv/tilemap_background_pixel_renderer.sv
bench/tb_tilemap_background_pixel_renderer.sv
